/* rtl/core/two_axis_rotator_position_controller_macros.svh */
// Assertion macros used by the rotator controller top level.
`ifndef TWO_AXIS_ROTATOR_POSITION_CONTROLLER_MACROS_SVH
`define TWO_AXIS_ROTATOR_POSITION_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked out of reset only
`define TRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define TRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRA_ASSERT(lbl, prop, msg)
`define TRA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/core/tra_pkg.sv */
// Types, constants and codes shared by the rotator controller modules.
package tra_pkg;

  localparam int CNT_W      = 24;  // signed pulse count width
  localparam int FRAC_W     = 8;   // fraction bits of the scale factors
  localparam int SCALE_W    = 16;
  localparam int POS_W      = 16;
  localparam int TOP_W      = 23;
  localparam int EDGE_W     = 4;
  localparam int OP_W       = 3;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CNT_W-1:0] CNT_HI = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic [CNT_W-1:0] CNT_LO = {1'b1, {(CNT_W-1){1'b0}}};

  localparam logic [SCALE_W-1:0] AZ_SCALE_RST = SCALE_W'(2916);
  localparam logic [SCALE_W-1:0] EL_SCALE_RST = SCALE_W'(2916);
  localparam logic [POS_W-1:0]   AZ_MAX_RST   = POS_W'(36000);
  localparam logic [POS_W-1:0]   EL_MAX_RST   = POS_W'(18000);
  localparam logic [TOP_W-1:0]   AZ_TOP_RST   = TOP_W'(3160);
  localparam logic [TOP_W-1:0]   EL_TOP_RST   = TOP_W'(1580);
  localparam logic [POS_W-1:0]   DEADBAND_RST = POS_W'(50);

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_SET_TARGET = 3'd1,
    OP_STOP       = 3'd2,
    OP_PARK       = 3'd3,
    OP_RIGHT      = 3'd4,
    OP_LEFT       = 3'd5,
    OP_UP         = 3'd6,
    OP_DOWN       = 3'd7
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE   = 2'd0,
    MODE_TRACK  = 2'd1,
    MODE_MANUAL = 2'd2,
    MODE_PARK   = 2'd3
  } mode_t;

  // positive is right/up, negative is left/down
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AZ_SCALE = 3'd0,
    CFG_EL_SCALE = 3'd1,
    CFG_AZ_MAX   = 3'd2,
    CFG_EL_MAX   = 3'd3,
    CFG_AZ_TOP   = 3'd4,
    CFG_EL_TOP   = 3'd5,
    CFG_DEADBAND = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [SCALE_W-1:0] az_scale;
    logic [SCALE_W-1:0] el_scale;
    logic [POS_W-1:0]   az_max;
    logic [POS_W-1:0]   el_max;
    logic [TOP_W-1:0]   az_top;
    logic [TOP_W-1:0]   el_top;
    logic [POS_W-1:0]   deadband;
  } cfg_t;

  // per-axis update controls for one item
  typedef struct packed {
    logic tick;       // apply limit switch and encoder edges
    logic park;       // drive toward zero, goal cleared
    logic zero_cnt;   // park finished: count cleared
    logic run_loop;   // close the position loop
    logic load_goal;  // set target
    logic stop;       // stop, goal takes current position
    logic move_pos;
    logic move_neg;
  } axis_ctl_t;

endpackage

/* rtl/core/tra_cfg.sv */
// Configuration register file of the rotator controller.
module tra_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tra_pkg::CFG_DATA_W-1:0] cfg_data,
  output tra_pkg::cfg_t                  cfg
);
  import tra_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_AZ_SCALE: cfg_nxt.az_scale = cfg_data[SCALE_W-1:0];
        CFG_EL_SCALE: cfg_nxt.el_scale = cfg_data[SCALE_W-1:0];
        CFG_AZ_MAX:   cfg_nxt.az_max   = cfg_data[POS_W-1:0];
        CFG_EL_MAX:   cfg_nxt.el_max   = cfg_data[POS_W-1:0];
        CFG_AZ_TOP:   cfg_nxt.az_top   = cfg_data[TOP_W-1:0];
        CFG_EL_TOP:   cfg_nxt.el_top   = cfg_data[TOP_W-1:0];
        CFG_DEADBAND: cfg_nxt.deadband = cfg_data[POS_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.az_scale <= AZ_SCALE_RST;
      cfg_r.el_scale <= EL_SCALE_RST;
      cfg_r.az_max   <= AZ_MAX_RST;
      cfg_r.el_max   <= EL_MAX_RST;
      cfg_r.az_top   <= AZ_TOP_RST;
      cfg_r.el_top   <= EL_TOP_RST;
      cfg_r.deadband <= DEADBAND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/core/tra_ctrl.sv */
// Mode register and opcode decode into per-axis update controls.
module tra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  tra_pkg::op_t       opcode,
  input  logic               az_limit_n,
  input  logic               el_limit_n,
  output tra_pkg::axis_ctl_t az_ctl,
  output tra_pkg::axis_ctl_t el_ctl,
  output tra_pkg::mode_t     mode_nxt
);
  import tra_pkg::*;

  mode_t mode_r;

  always_comb begin
    az_ctl   = '0;
    el_ctl   = '0;
    mode_nxt = mode_r;
    unique case (opcode)
      OP_TICK: begin
        az_ctl.tick = 1'b1;
        el_ctl.tick = 1'b1;
        if (mode_r == MODE_PARK) begin
          az_ctl.park = 1'b1;
          el_ctl.park = 1'b1;
          // both axes home: parking is done
          if (!az_limit_n && !el_limit_n) begin
            az_ctl.zero_cnt = 1'b1;
            el_ctl.zero_cnt = 1'b1;
            mode_nxt        = MODE_IDLE;
          end
        end else if (mode_r != MODE_MANUAL) begin
          az_ctl.run_loop = 1'b1;
          el_ctl.run_loop = 1'b1;
        end
      end
      OP_SET_TARGET: begin
        az_ctl.load_goal = 1'b1;
        el_ctl.load_goal = 1'b1;
        mode_nxt         = MODE_TRACK;
      end
      OP_STOP: begin
        az_ctl.stop = 1'b1;
        el_ctl.stop = 1'b1;
        mode_nxt    = MODE_IDLE;
      end
      OP_PARK: mode_nxt = MODE_PARK;
      OP_RIGHT: begin
        az_ctl.move_pos = 1'b1;
        mode_nxt        = MODE_MANUAL;
      end
      OP_LEFT: begin
        az_ctl.move_neg = 1'b1;
        mode_nxt        = MODE_MANUAL;
      end
      OP_UP: begin
        el_ctl.move_pos = 1'b1;
        mode_nxt        = MODE_MANUAL;
      end
      OP_DOWN: begin
        el_ctl.move_neg = 1'b1;
        mode_nxt        = MODE_MANUAL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (adv) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

/* rtl/core/tra_axis.sv */
// One rotator axis: pulse count, drive direction, goal and position loop.
module tra_axis (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  tra_pkg::axis_ctl_t           ctl,
  input  logic [tra_pkg::EDGE_W-1:0]   edges,
  input  logic                         limit_n,
  input  logic [tra_pkg::POS_W-1:0]    target,
  input  logic [tra_pkg::SCALE_W-1:0]  scale,
  input  logic [tra_pkg::POS_W-1:0]    max_pos,
  input  logic [tra_pkg::TOP_W-1:0]    top_count,
  input  logic [tra_pkg::POS_W-1:0]    deadband,
  output tra_pkg::dir_t                dir_nxt,
  output logic [tra_pkg::POS_W-1:0]    pos_nxt
);
  import tra_pkg::*;

  localparam int EXT_W  = ((CNT_W > TOP_W) ? CNT_W : TOP_W) + 1;
  localparam int PROD_W = CNT_W - 1 + SCALE_W + 1;  // product plus rounding carry
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_W - 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  dir_t             dir_r;
  logic [POS_W-1:0] goal_r, goal_nxt;

  logic [CNT_W-1:0] cnt_a, cnt_b;
  dir_t             dir_a;
  logic [POS_W-1:0] pos_b;

  // top count clipped to the positive count range
  function automatic logic [CNT_W-1:0] sat_top(input logic [TOP_W-1:0] top);
    logic [EXT_W-1:0] t;
    t = EXT_W'(top);
    if (t > EXT_W'(CNT_HI)) begin
      return CNT_HI;
    end
    return t[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] add_sat(input logic [CNT_W-1:0]  cnt,
                                               input logic [EDGE_W-1:0] e,
                                               input logic              sub);
    logic [CNT_W:0] s;
    logic [CNT_W:0] ext;
    ext = (CNT_W+1)'(e);
    s   = sub ? ({cnt[CNT_W-1], cnt} - ext) : ({cnt[CNT_W-1], cnt} + ext);
    if (s[CNT_W] != s[CNT_W-1]) begin
      return s[CNT_W] ? CNT_LO : CNT_HI;
    end
    return s[CNT_W-1:0];
  endfunction

  // (count * scale + half) >> FRAC_W, zero for non-positive counts, clamped to max
  function automatic logic [POS_W-1:0] pos_of(input logic [CNT_W-1:0]   cnt,
                                              input logic [SCALE_W-1:0] sc,
                                              input logic [POS_W-1:0]   mx);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rnd;
    prod = PROD_W'(cnt[CNT_W-2:0]) * PROD_W'(sc);
    rnd  = (prod + HALF) >> FRAC_W;
    if (cnt[CNT_W-1] || (cnt == '0)) begin
      return '0;
    end
    if (rnd > PROD_W'(mx)) begin
      return mx;
    end
    return rnd[POS_W-1:0];
  endfunction

  always_comb begin
    dir_a = dir_r;
    cnt_a = count_r;
    cnt_b = count_r;
    if (ctl.tick) begin
      if (!limit_n) begin
        dir_a = DIR_STOP;
        if (dir_r == DIR_POS) begin
          cnt_a = sat_top(top_count);
        end else if (dir_r == DIR_NEG) begin
          cnt_a = '0;
        end
      end
      // edges counted with the direction held before the limit took effect
      cnt_b = cnt_a;
      if (dir_r == DIR_POS) begin
        cnt_b = add_sat(cnt_a, edges, 1'b0);
      end else if (dir_r == DIR_NEG) begin
        cnt_b = add_sat(cnt_a, edges, 1'b1);
      end
    end
  end

  assign pos_b = pos_of(cnt_b, scale, max_pos);

  always_comb begin
    dir_nxt   = dir_a;
    count_nxt = cnt_b;
    goal_nxt  = goal_r;
    pos_nxt   = pos_b;
    if (ctl.park) begin
      goal_nxt = '0;
      dir_nxt  = DIR_NEG;
      if (ctl.zero_cnt) begin
        count_nxt = '0;
        pos_nxt   = '0;
      end
    end
    if (ctl.run_loop) begin
      if ((goal_r > pos_b) && ((goal_r - pos_b) > deadband)) begin
        dir_nxt = DIR_POS;
      end else if ((pos_b > goal_r) && ((pos_b - goal_r) > deadband)) begin
        dir_nxt = DIR_NEG;
      end else begin
        dir_nxt = DIR_STOP;
      end
    end
    if (ctl.load_goal) begin
      goal_nxt = (target > max_pos) ? max_pos : target;
    end
    if (ctl.stop) begin
      dir_nxt  = DIR_STOP;
      goal_nxt = pos_b;
    end
    if (ctl.move_pos) begin
      dir_nxt = DIR_POS;
    end
    if (ctl.move_neg) begin
      dir_nxt = DIR_NEG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      dir_r   <= DIR_STOP;
      goal_r  <= '0;
    end else if (adv) begin
      count_r <= count_nxt;
      dir_r   <= dir_nxt;
      goal_r  <= goal_nxt;
    end
  end

endmodule

/* rtl/core/two_axis_rotator_position_controller.sv */
// Top level of the two-axis rotator position controller.
// An accepted item goes into an input register; once the output register is free or being
// emptied, the axis logic applies it to the state and the result lands in an output register
// that drives out_valid and the status outputs. With out_ready high one item is taken every
// cycle; while a result waits on out_ready, one further item is held in the input register
// and in_ready then drops. The per-cycle state loop holds a saturating count update, one
// 23x16-bit multiply per axis (count to position) and the deadband compare. Configuration
// writes are taken every cycle (cfg_ready is tied high) and belong in idle periods only.
module two_axis_rotator_position_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tra_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tra_pkg::OP_W-1:0]       in_opcode,
  input  logic [tra_pkg::POS_W-1:0]      in_target_az,
  input  logic [tra_pkg::POS_W-1:0]      in_target_el,
  input  logic [tra_pkg::EDGE_W-1:0]     in_az_edges,
  input  logic [tra_pkg::EDGE_W-1:0]     in_el_edges,
  input  logic                           in_az_limit_n,
  input  logic                           in_el_limit_n,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_drive_right,
  output logic                           out_drive_left,
  output logic                           out_drive_up,
  output logic                           out_drive_down,
  output logic [tra_pkg::POS_W-1:0]      out_az_position,
  output logic [tra_pkg::POS_W-1:0]      out_el_position,
  output logic [tra_pkg::MODE_W-1:0]     out_mode
);
  import tra_pkg::*;

  `include "two_axis_rotator_position_controller_macros.svh"

  cfg_t cfg;

  // input register
  logic              in_vld_r;
  op_t               op_r;
  logic [POS_W-1:0]  taz_r, tel_r;
  logic [EDGE_W-1:0] aze_r, ele_r;
  logic              azl_r, ell_r;

  // output register
  logic              out_vld_r;
  logic              drv_r_r, drv_l_r, drv_u_r, drv_d_r;
  logic [POS_W-1:0]  azp_r, elp_r;
  mode_t             mode_out_r;

  logic       adv;
  axis_ctl_t  az_ctl, el_ctl;
  mode_t      mode_nxt;
  dir_t       az_dir_nxt, el_dir_nxt;
  logic [POS_W-1:0] az_pos_nxt, el_pos_nxt;

  // the held item moves on when the output register is free or being emptied
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  tra_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .opcode     (op_r),
    .az_limit_n (azl_r),
    .el_limit_n (ell_r),
    .az_ctl     (az_ctl),
    .el_ctl     (el_ctl),
    .mode_nxt   (mode_nxt)
  );

  tra_axis u_az (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl       (az_ctl),
    .edges     (aze_r),
    .limit_n   (azl_r),
    .target    (taz_r),
    .scale     (cfg.az_scale),
    .max_pos   (cfg.az_max),
    .top_count (cfg.az_top),
    .deadband  (cfg.deadband),
    .dir_nxt   (az_dir_nxt),
    .pos_nxt   (az_pos_nxt)
  );

  tra_axis u_el (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl       (el_ctl),
    .edges     (ele_r),
    .limit_n   (ell_r),
    .target    (tel_r),
    .scale     (cfg.el_scale),
    .max_pos   (cfg.el_max),
    .top_count (cfg.el_top),
    .deadband  (cfg.deadband),
    .dir_nxt   (el_dir_nxt),
    .pos_nxt   (el_pos_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= op_t'(in_opcode);
      taz_r <= in_target_az;
      tel_r <= in_target_el;
      aze_r <= in_az_edges;
      ele_r <= in_el_edges;
      azl_r <= in_az_limit_n;
      ell_r <= in_el_limit_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drv_r_r    <= (az_dir_nxt == DIR_POS);
      drv_l_r    <= (az_dir_nxt == DIR_NEG);
      drv_u_r    <= (el_dir_nxt == DIR_POS);
      drv_d_r    <= (el_dir_nxt == DIR_NEG);
      azp_r      <= az_pos_nxt;
      elp_r      <= el_pos_nxt;
      mode_out_r <= mode_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_drive_right = drv_r_r;
  assign out_drive_left  = drv_l_r;
  assign out_drive_up    = drv_u_r;
  assign out_drive_down  = drv_d_r;
  assign out_az_position = azp_r;
  assign out_el_position = elp_r;
  assign out_mode        = mode_out_r;

  `TRA_ASSERT(a_in_held, (in_valid && in_ready) |=> in_vld_r, "input transfer not captured")
  `TRA_ASSERT(a_adv_out, adv |=> out_vld_r, "processed item produced no result")
  `TRA_ASSERT(a_drive_excl, out_vld_r |-> !(drv_r_r && drv_l_r) && !(drv_u_r && drv_d_r), "opposing drives on together")
  `TRA_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_vld_r && !in_vld_r, "pipeline not empty after reset")

endmodule

/* dv/two_axis_rotator_position_controller_tb.sv */
// Self-checking testbench for the two-axis rotator position controller.
module two_axis_rotator_position_controller_tb;
  import tra_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;  // index with no register behind it
  localparam int RAND_PER_SETTING = 300;
  localparam int NUM_SETTINGS     = 6;
  localparam int LONG_HOLD        = 250;

  typedef struct packed {
    op_t                op;
    logic [POS_W-1:0]   target_az;
    logic [POS_W-1:0]   target_el;
    logic [EDGE_W-1:0]  az_edges;
    logic [EDGE_W-1:0]  el_edges;
    logic               az_lim;
    logic               el_lim;
  } rotor_cmd_t;

  typedef struct packed {
    logic             drive_right;
    logic             drive_left;
    logic             drive_up;
    logic             drive_down;
    logic [POS_W-1:0] az_pos;
    logic [POS_W-1:0] el_pos;
    mode_t            mode;
  } rotor_status_t;

  class rotor_scoreboard;
    bit [SCALE_W-1:0] az_scale, el_scale;
    bit [POS_W-1:0]   az_max, el_max, deadband;
    bit [TOP_W-1:0]   az_top, el_top;
    mode_t            mode;
    dir_t             az_dir, el_dir;
    longint           az_cnt, el_cnt;
    bit [POS_W-1:0]   az_goal, el_goal;
    rotor_status_t    status_q[$];
    int               errors, checked, parks_done, limit_hits;

    function new();
      az_scale = AZ_SCALE_RST; el_scale = EL_SCALE_RST;
      az_max   = AZ_MAX_RST;   el_max   = EL_MAX_RST;
      az_top   = AZ_TOP_RST;   el_top   = EL_TOP_RST;
      deadband = DEADBAND_RST;
      mode     = MODE_IDLE;
      az_dir   = DIR_STOP;     el_dir   = DIR_STOP;
      az_cnt   = 0;            el_cnt   = 0;
      az_goal  = '0;           el_goal  = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_AZ_SCALE: az_scale = data[SCALE_W-1:0];
        CFG_EL_SCALE: el_scale = data[SCALE_W-1:0];
        CFG_AZ_MAX:   az_max   = data[POS_W-1:0];
        CFG_EL_MAX:   el_max   = data[POS_W-1:0];
        CFG_AZ_TOP:   az_top   = data[TOP_W-1:0];
        CFG_EL_TOP:   el_top   = data[TOP_W-1:0];
        CFG_DEADBAND: deadband = data[POS_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip_count(longint v);
      longint hi;
      hi = longint'(CNT_HI);
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // count * Q8.8 scale, rounded half up, clamped to the axis maximum
    function bit [POS_W-1:0] angle_of(longint c, bit [SCALE_W-1:0] s, bit [POS_W-1:0] m);
      longint unsigned p;
      if (c <= 0) return '0;
      p = c;
      p = p * s;
      p = (p + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
      if (p > m) p = 64'(m);
      return p[POS_W-1:0];
    endfunction

    function longint add_edges(longint c, dir_t d, bit [EDGE_W-1:0] e);
      longint ev;
      ev = longint'(e);
      if (d == DIR_POS) return clip_count(c + ev);
      if (d == DIR_NEG) return clip_count(c - ev);
      return c;
    endfunction

    function dir_t steer(bit [POS_W-1:0] goal, bit [POS_W-1:0] pos);
      int d;
      d = int'(goal) - int'(pos);
      if (d > int'(deadband)) return DIR_POS;
      if (-d > int'(deadband)) return DIR_NEG;
      return DIR_STOP;
    endfunction

    function void note_input(rotor_cmd_t it);
      dir_t          az_was, el_was;
      rotor_status_t want;
      az_was = az_dir;
      el_was = el_dir;
      case (it.op)
        OP_TICK: begin
          if (!it.az_lim) begin
            if (az_dir != DIR_STOP) limit_hits++;
            if (az_dir == DIR_POS) az_cnt = clip_count(longint'(az_top));
            else if (az_dir == DIR_NEG) az_cnt = 0;
            az_dir = DIR_STOP;
          end
          if (!it.el_lim) begin
            if (el_dir != DIR_STOP) limit_hits++;
            if (el_dir == DIR_POS) el_cnt = clip_count(longint'(el_top));
            else if (el_dir == DIR_NEG) el_cnt = 0;
            el_dir = DIR_STOP;
          end
          // edges follow the direction held when the tick arrived
          az_cnt = add_edges(az_cnt, az_was, it.az_edges);
          el_cnt = add_edges(el_cnt, el_was, it.el_edges);
          if (mode == MODE_PARK) begin
            az_goal = '0;
            el_goal = '0;
            az_dir  = DIR_NEG;
            el_dir  = DIR_NEG;
            if (!it.az_lim && !it.el_lim) begin
              az_cnt = 0;
              el_cnt = 0;
              mode   = MODE_IDLE;
              parks_done++;
            end
          end else if (mode != MODE_MANUAL) begin
            az_dir = steer(az_goal, angle_of(az_cnt, az_scale, az_max));
            el_dir = steer(el_goal, angle_of(el_cnt, el_scale, el_max));
          end
        end
        OP_SET_TARGET: begin
          az_goal = (it.target_az > az_max) ? az_max : it.target_az;
          el_goal = (it.target_el > el_max) ? el_max : it.target_el;
          mode    = MODE_TRACK;
        end
        OP_STOP: begin
          az_dir  = DIR_STOP;
          el_dir  = DIR_STOP;
          az_goal = angle_of(az_cnt, az_scale, az_max);
          el_goal = angle_of(el_cnt, el_scale, el_max);
          mode    = MODE_IDLE;
        end
        OP_PARK:  mode = MODE_PARK;
        OP_RIGHT: begin az_dir = DIR_POS; mode = MODE_MANUAL; end
        OP_LEFT:  begin az_dir = DIR_NEG; mode = MODE_MANUAL; end
        OP_UP:    begin el_dir = DIR_POS; mode = MODE_MANUAL; end
        default:  begin el_dir = DIR_NEG; mode = MODE_MANUAL; end
      endcase
      want.drive_right = (az_dir == DIR_POS);
      want.drive_left  = (az_dir == DIR_NEG);
      want.drive_up    = (el_dir == DIR_POS);
      want.drive_down  = (el_dir == DIR_NEG);
      want.az_pos      = angle_of(az_cnt, az_scale, az_max);
      want.el_pos      = angle_of(el_cnt, el_scale, el_max);
      want.mode        = mode;
      status_q = {status_q, want};
    endfunction

    function void compare_field(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      end
    endfunction

    function void check_result(rotor_status_t got);
      rotor_status_t want;
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result with no transfer outstanding, expected none, actual az %0d el %0d",
                   $time, got.az_pos, got.el_pos);
        return;
      end
      want = status_q.pop_front();
      checked++;
      compare_field("drive_right", 32'(want.drive_right), 32'(got.drive_right));
      compare_field("drive_left",  32'(want.drive_left),  32'(got.drive_left));
      compare_field("drive_up",    32'(want.drive_up),    32'(got.drive_up));
      compare_field("drive_down",  32'(want.drive_down),  32'(got.drive_down));
      compare_field("az_position", 32'(want.az_pos),      32'(got.az_pos));
      compare_field("el_position", 32'(want.el_pos),      32'(got.el_pos));
      compare_field("mode",        32'(want.mode),        32'(got.mode));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_opcode = '0;
  logic [POS_W-1:0]      in_target_az = '0;
  logic [POS_W-1:0]      in_target_el = '0;
  logic [EDGE_W-1:0]     in_az_edges = '0;
  logic [EDGE_W-1:0]     in_el_edges = '0;
  logic                  in_az_limit_n = 1'b1;
  logic                  in_el_limit_n = 1'b1;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_drive_right, out_drive_left, out_drive_up, out_drive_down;
  logic [POS_W-1:0]      out_az_position, out_el_position;
  logic [MODE_W-1:0]     out_mode;

  rotor_scoreboard sb;
  int              items_sent = 0;
  int              directed_items = 0;
  int              burst_left = 0;
  int              hold_left = 0;
  int              holds_asked = 0;
  int              holds_done = 0;
  int              ready_style = 0;
  int              style_left = 0;
  logic [31:0]     cyc = '0;

  two_axis_rotator_position_controller u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_target_az   (in_target_az),
    .in_target_el   (in_target_el),
    .in_az_edges    (in_az_edges),
    .in_el_edges    (in_el_edges),
    .in_az_limit_n  (in_az_limit_n),
    .in_el_limit_n  (in_el_limit_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_drive_right(out_drive_right),
    .out_drive_left (out_drive_left),
    .out_drive_up   (out_drive_up),
    .out_drive_down (out_drive_down),
    .out_az_position(out_az_position),
    .out_el_position(out_el_position),
    .out_mode       (out_mode)
  );

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("two_axis_rotator_position_controller_tb: done, errors");
    $finish;
  end

  // result side: check every transfer, stall on a changing pattern
  always @(posedge clk) begin
    rotor_status_t got;
    if (rst_n && out_valid && out_ready) begin
      got.drive_right = out_drive_right;
      got.drive_left  = out_drive_left;
      got.drive_up    = out_drive_up;
      got.drive_down  = out_drive_down;
      got.az_pos      = out_az_position;
      got.el_pos      = out_el_position;
      got.mode        = mode_t'(out_mode);
      sb.check_result(got);
    end
    cyc <= cyc + 1;
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < holds_asked) begin
      out_ready  <= 1'b0;
      hold_left  <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else begin
      if (style_left == 0) begin
        ready_style <= $urandom_range(0, 3);
        style_left  <= $urandom_range(20, 200);
      end else begin
        style_left <= style_left - 1;
      end
      case (ready_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) != 0);
        2:       out_ready <= ($urandom_range(0, 9) != 0);
        default: out_ready <= (cyc[1:0] == 2'd0);
      endcase
    end
  end

  // input side: bursts with random gaps, no gaps while the output is held off
  task automatic offer(rotor_cmd_t it);
    if (burst_left == 0 && hold_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    in_valid      <= 1'b1;
    in_opcode     <= it.op;
    in_target_az  <= it.target_az;
    in_target_el  <= it.target_el;
    in_az_edges   <= it.az_edges;
    in_el_edges   <= it.el_edges;
    in_az_limit_n <= it.az_lim;
    in_el_limit_n <= it.el_lim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    items_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // stop offering and let every outstanding result come back
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic rotor_cmd_t mk(op_t op, int taz, int tel, int aze, int ele,
                                    bit azl, bit ell);
    rotor_cmd_t it;
    it.op        = op;
    it.target_az = POS_W'(taz);
    it.target_el = POS_W'(tel);
    it.az_edges  = EDGE_W'(aze);
    it.el_edges  = EDGE_W'(ele);
    it.az_lim    = azl;
    it.el_lim    = ell;
    return it;
  endfunction

  function automatic rotor_cmd_t rand_item();
    return mk(op_t'($urandom_range(0, 7)), $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 15), $urandom_range(0, 15),
              ($urandom_range(0, 1) != 0), ($urandom_range(0, 1) != 0));
  endfunction

  // switch mostly released, closed now and then
  function automatic bit switch_level();
    return $urandom_range(0, 99) >= 3;
  endfunction

  function automatic rotor_cmd_t tick_item(bit azl, bit ell);
    rotor_cmd_t it;
    it        = rand_item();
    it.op     = OP_TICK;
    it.az_lim = azl;
    it.el_lim = ell;
    return it;
  endfunction

  task automatic run_directed();
    int first;
    first = items_sent;
    offer(mk(OP_TICK, 0, 0, 0, 0, 1, 1));
    offer(mk(OP_SET_TARGET, 65535, 65535, 0, 0, 1, 1));  // both clamped to max
    offer(mk(OP_TICK, 0, 0, 15, 15, 1, 1));
    offer(mk(OP_TICK, 0, 0, 15, 15, 1, 1));
    offer(mk(OP_TICK, 0, 0, 15, 15, 0, 0));              // upper limits while moving up
    offer(mk(OP_TICK, 0, 0, 0, 0, 1, 1));
    offer(mk(OP_RIGHT, 0, 0, 0, 0, 1, 1));
    offer(mk(OP_LEFT, 0, 0, 0, 0, 1, 1));
    offer(mk(OP_UP, 0, 0, 0, 0, 1, 1));
    offer(mk(OP_DOWN, 0, 0, 0, 0, 1, 1));
    offer(mk(OP_TICK, 0, 0, 15, 15, 1, 1));
    offer(mk(OP_TICK, 0, 0, 15, 15, 0, 0));              // lower limits, count goes negative
    offer(mk(OP_SET_TARGET, 0, 0, 0, 0, 1, 1));
    offer(mk(OP_TICK, 0, 0, 3, 3, 1, 1));
    offer(mk(OP_SET_TARGET, 1000, 500, 15, 15, 0, 0));   // command ignores edges and limits
    offer(mk(OP_TICK, 0, 0, 0, 0, 1, 1));
    offer(mk(OP_TICK, 0, 0, 15, 15, 1, 1));
    offer(mk(OP_STOP, 65535, 65535, 15, 15, 1, 1));
    offer(mk(OP_PARK, 0, 0, 0, 0, 1, 1));
    offer(mk(OP_TICK, 0, 0, 4, 4, 0, 1));
    offer(mk(OP_TICK, 0, 0, 4, 4, 1, 0));
    offer(mk(OP_TICK, 0, 0, 2, 2, 0, 0));                // park complete
    offer(mk(OP_TICK, 0, 0, 0, 0, 1, 1));
    directed_items = items_sent - first;
  endtask

  task automatic random_sequence();
    rotor_cmd_t it;
    int         kind, n, az_at, el_at;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      it    = rand_item();
      it.op = OP_SET_TARGET;
      if ($urandom_range(0, 3) != 0) begin
        it.target_az = POS_W'($urandom_range(0, sb.az_max));
        it.target_el = POS_W'($urandom_range(0, sb.el_max));
      end
      offer(it);
      repeat ($urandom_range(5, 60)) offer(tick_item(switch_level(), switch_level()));
    end else if (kind < 55) begin
      repeat ($urandom_range(1, 3)) begin
        it    = rand_item();
        it.op = op_t'($urandom_range(int'(OP_RIGHT), int'(OP_DOWN)));
        offer(it);
        repeat ($urandom_range(3, 30)) offer(tick_item(switch_level(), switch_level()));
      end
    end else if (kind < 70) begin
      it    = rand_item();
      it.op = OP_PARK;
      offer(it);
      n     = $urandom_range(4, 40);
      az_at = $urandom_range(1, n - 1);
      el_at = $urandom_range(1, n - 1);
      if ($urandom_range(0, 3) == 0) el_at = n + 1;  // abandoned before both limits
      for (int i = 0; i < n; i++) offer(tick_item(i < az_at, i < el_at));
      repeat ($urandom_range(0, 3)) offer(tick_item(1'b1, 1'b1));
    end else if (kind < 80) begin
      it    = rand_item();
      it.op = OP_STOP;
      offer(it);
      repeat ($urandom_range(1, 10)) offer(tick_item(switch_level(), switch_level()));
    end else begin
      repeat ($urandom_range(1, 5)) offer(rand_item());
    end
  endtask

  task automatic configure(int setting);
    case (setting)
      1: begin  // upper extremes, no deadband
        put_reg(CFG_AZ_SCALE, 23'h7FFFFF);
        put_reg(CFG_EL_SCALE, 23'h00FFFF);
        put_reg(CFG_AZ_MAX,   23'h00FFFF);
        put_reg(CFG_EL_MAX,   23'h7FFFFF);
        put_reg(CFG_AZ_TOP,   23'h7FFFFF);
        put_reg(CFG_EL_TOP,   23'h7FFFFF);
        put_reg(CFG_DEADBAND, 23'h000000);
      end
      2: begin  // lower extremes, widest deadband
        put_reg(CFG_AZ_SCALE, 23'h000000);
        put_reg(CFG_EL_SCALE, 23'h000000);
        put_reg(CFG_AZ_MAX,   23'h000000);
        put_reg(CFG_EL_MAX,   23'h000000);
        put_reg(CFG_AZ_TOP,   23'h000000);
        put_reg(CFG_EL_TOP,   23'h000000);
        put_reg(CFG_DEADBAND, 23'h00FFFF);
      end
      3: begin  // fine resolution
        put_reg(CFG_AZ_SCALE, CFG_DATA_W'($urandom_range(1, 64)));
        put_reg(CFG_EL_SCALE, CFG_DATA_W'($urandom_range(1, 64)));
        put_reg(CFG_AZ_MAX,   CFG_DATA_W'($urandom_range(0, 65535)));
        put_reg(CFG_EL_MAX,   CFG_DATA_W'($urandom_range(0, 65535)));
        put_reg(CFG_AZ_TOP,   CFG_DATA_W'($urandom_range(0, 4000)));
        put_reg(CFG_EL_TOP,   CFG_DATA_W'($urandom_range(0, 4000)));
        put_reg(CFG_DEADBAND, CFG_DATA_W'($urandom_range(0, 20)));
      end
      4: begin  // anything goes, junk in the unused upper data bits
        put_reg(CFG_AZ_SCALE, CFG_DATA_W'($urandom()));
        put_reg(CFG_EL_SCALE, CFG_DATA_W'($urandom()));
        put_reg(CFG_AZ_MAX,   CFG_DATA_W'($urandom()));
        put_reg(CFG_EL_MAX,   CFG_DATA_W'($urandom()));
        put_reg(CFG_AZ_TOP,   CFG_DATA_W'($urandom()));
        put_reg(CFG_EL_TOP,   CFG_DATA_W'($urandom()));
        put_reg(CFG_DEADBAND, CFG_DATA_W'($urandom_range(0, 400)));
        put_reg(CFG_UNUSED,   CFG_DATA_W'($urandom()));
      end
      default: begin
        put_reg(CFG_AZ_SCALE, CFG_DATA_W'(AZ_SCALE_RST));
        put_reg(CFG_EL_SCALE, CFG_DATA_W'(EL_SCALE_RST));
        put_reg(CFG_AZ_MAX,   CFG_DATA_W'(AZ_MAX_RST));
        put_reg(CFG_EL_MAX,   CFG_DATA_W'(EL_MAX_RST));
        put_reg(CFG_AZ_TOP,   AZ_TOP_RST);
        put_reg(CFG_EL_TOP,   EL_TOP_RST);
        put_reg(CFG_DEADBAND, CFG_DATA_W'($urandom_range(0, 100)));
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int start;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
      if (setting != 0) begin
        settle();
        configure(setting);
      end
      if (setting == 1 || setting == 4) holds_asked <= holds_asked + 1;
      start = items_sent;
      while (items_sent - start < RAND_PER_SETTING) random_sequence();
    end
    settle();
    repeat (8) @(posedge clk);
    $display("%0d transfers (%0d directed) across %0d register settings, %0d results checked",
             items_sent, directed_items, NUM_SETTINGS, sb.checked);
    $display("%0d limit stops, %0d completed parks, %0d long output stalls",
             sb.limit_hits, sb.parks_done, holds_done);
    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("two_axis_rotator_position_controller_tb: done, clean");
    end else begin
      $display("two_axis_rotator_position_controller_tb: done, errors");
    end
    $finish;
  end

endmodule
